// ===== design/totp_hmac_sha1_generator_core_macros.svh =====
// Assertion macros for the TOTP HMAC-SHA1 generator core.
// Included by the top level; no other dependencies.
`ifndef TOTP_HMAC_SHA1_GENERATOR_CORE_MACROS_SVH
`define TOTP_HMAC_SHA1_GENERATOR_CORE_MACROS_SVH
// implication checked in the next cycle
`define TOTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
// implication checked in the same cycle
`define TOTP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`endif

// ===== design/totp_pkg.sv =====
// Shared types and constants of the TOTP HMAC-SHA1 generator.
// No dependencies.
`timescale 1ns / 1ps
package totp_pkg;
  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_LOAD, ST_ROUND, ST_FOLD, ST_TRUNC, ST_OUT
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       div_step;
    logic       blk_load;
    logic       round;
    logic       fold;
    logic       trunc;
    logic [1:0] blk;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic round_last;
  } stat_t;

  localparam logic [2:0] REG_KEY_A   = 3'd0;
  localparam logic [2:0] REG_KEY_B   = 3'd1;
  localparam logic [2:0] REG_KEY_C   = 3'd2;
  localparam logic [2:0] REG_KEY_D   = 3'd3;
  localparam logic [2:0] REG_KEY_LEN = 3'd4;

  localparam logic [1:0] BLK_IKEY = 2'd0;
  localparam logic [1:0] BLK_ITAIL = 2'd1;
  localparam logic [1:0] BLK_OKEY = 2'd2;
  localparam logic [1:0] BLK_OTAIL = 2'd3;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5C;
  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam logic [31:0] ITAIL_BITS = 32'd576;
  localparam logic [31:0] OTAIL_BITS = 32'd672;
  localparam int KEY_STORE_BYTES = 32;
  localparam logic [6:0] DIV_LAST = 7'd15;
  localparam logic [6:0] ROUND_LAST = 7'd79;
endpackage

// ===== design/totp_hmac_sha1_generator_core.sv =====
// TOTP HMAC-SHA1 generator: one 16-bit code per 64-bit timestamp.
// Work per request: a byte-wise divide yielding 8 quotient bytes, then four SHA-1 blocks
// (load, 80 rounds, fold each), then one truncation; the code is held until taken.
// One request at a time; the SHA-1 unit computes one round per cycle.
// Synchronous active-high reset clears the key registers and controller.
`timescale 1ns / 1ps
`include "totp_hmac_sha1_generator_core_macros.svh"
module totp_hmac_sha1_generator_core import totp_pkg::*; #(
  parameter int MAX_KEY_BYTES = 32,
  parameter int TIME_STEP     = 300
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // timestamp[63:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // code[15:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  logic [63:0] key_a, key_b, key_c, key_d;
  logic [5:0]  key_length;
  cmd_t        cmd;
  stat_t       stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_a <= '0; key_b <= '0; key_c <= '0; key_d <= '0;
      key_length <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_A:   key_a <= cfg_data;
        REG_KEY_B:   key_b <= cfg_data;
        REG_KEY_C:   key_c <= cfg_data;
        REG_KEY_D:   key_d <= cfg_data;
        REG_KEY_LEN: key_length <= cfg_data[5:0];
        default:     key_length <= key_length;
      endcase
    end
  end

  totp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .cmd       (cmd)
  );

  totp_dpath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .TIME_STEP     (TIME_STEP)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .timestamp  (s_tdata),
    .key        ({key_a, key_b, key_c, key_d}),
    .key_length (key_length),
    .stat       (stat),
    .code       (m_tdata)
  );

  `TOTP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `TOTP_ASSERT_NOW(a_no_accept_with_result, m_tvalid, !s_tready)
  `TOTP_ASSERT_NEXT(a_ready_after_result, m_tvalid && m_tready, s_tready && !m_tvalid)
endmodule

// ===== design/totp_ctrl.sv =====
// Controller of the TOTP generator: sequences divide, four SHA-1 blocks, truncation and output.
// Depends on totp_pkg.
`timescale 1ns / 1ps
module totp_ctrl import totp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output logic  in_ready,
  output logic  out_valid,
  output cmd_t  cmd
);
  state_t     state, state_next;
  logic [1:0] blk, blk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      blk   <= BLK_IKEY;
    end else begin
      state <= state_next;
      blk   <= blk_next;
    end
  end

  always_comb begin
    state_next = state;
    blk_next   = blk;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_DIV;
      ST_DIV:   if (stat.div_last) begin
        state_next = ST_LOAD;
        blk_next   = BLK_IKEY;
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: if (stat.round_last) state_next = ST_FOLD;
      ST_FOLD:  begin
        if (blk == BLK_OTAIL) begin
          state_next = ST_TRUNC;
        end else begin
          state_next = ST_LOAD;
          blk_next   = blk + 2'd1;
        end
      end
      ST_TRUNC: state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.blk      = blk;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state)
      ST_IDLE:  begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_DIV:   cmd.div_step = 1'b1;
      ST_LOAD:  cmd.blk_load = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD:  cmd.fold = 1'b1;
      ST_TRUNC: cmd.trunc = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      default:  cmd = '0;
    endcase
  end
endmodule

// ===== design/totp_dpath.sv =====
// Datapath of the TOTP generator: byte-wise reciprocal divider, SHA-1 round unit, truncation.
// Depends on totp_pkg.
`timescale 1ns / 1ps
module totp_dpath import totp_pkg::*; #(
  parameter int MAX_KEY_BYTES = 32,
  parameter int TIME_STEP     = 300
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [63:0] timestamp,
  input  logic [255:0] key,
  input  logic [5:0]  key_length,
  output stat_t       stat,
  output logic [15:0] code
);
  localparam int RW = $clog2(TIME_STEP) + 1;
  localparam int RB = RW + 8;
  localparam int DS = 2 * $clog2(TIME_STEP) + 8;
  localparam int MW = $clog2(TIME_STEP) + 10;
  localparam int LIM_CAP = (MAX_KEY_BYTES < KEY_STORE_BYTES) ? MAX_KEY_BYTES : KEY_STORE_BYTES;
  localparam logic [63:0] RECIP =
    ((64'd1 << DS) + 64'(TIME_STEP) - 64'd1) / 64'(TIME_STEP);
  localparam logic [MW-1:0] RECIP_M = RECIP[MW-1:0];
  localparam logic [RB-1:0] TS = RB'(TIME_STEP);

  logic [6:0]    cnt;
  logic [63:0]   quo;
  logic [RW-1:0] rem;
  logic [31:0]   h [5];
  logic [31:0]   a, b, c, d, e;
  logic [31:0]   w [16];
  logic [159:0]  idig;

  // divider digit: each quotient byte is first estimated into qd, then shifted into quo as the remainder updates
  logic [RB-1:0]    dr;
  logic [RB+MW-1:0] dprod;
  logic [7:0]       qd;
  assign dr    = {rem, quo[63:56]};
  assign dprod = {{MW{1'b0}}, dr} * {{RB{1'b0}}, RECIP_M};

  // key masking
  logic [6:0]   lim;
  logic [255:0] kmask;
  always_comb begin
    lim = (7'(key_length) > 7'(LIM_CAP)) ? 7'(LIM_CAP) : 7'(key_length);
    for (int j = 0; j < 32; j++) begin
      kmask[255-8*j -: 8] = (7'(j) < lim) ? key[255-8*j -: 8] : 8'h00;
    end
  end

  // block word generation
  logic [31:0] blkw [16];
  logic [7:0]  padb;
  always_comb begin
    padb = cmd.blk[1] ? OPAD : IPAD;
    for (int i = 0; i < 16; i++) blkw[i] = '0;
    unique case (cmd.blk)
      BLK_IKEY, BLK_OKEY: begin
        for (int i = 0; i < 8; i++) blkw[i] = kmask[255-32*i -: 32] ^ {4{padb}};
        for (int i = 8; i < 16; i++) blkw[i] = {4{padb}};
      end
      BLK_ITAIL: begin
        blkw[0]  = quo[63:32];
        blkw[1]  = quo[31:0];
        blkw[2]  = PAD_WORD;
        blkw[15] = ITAIL_BITS;
      end
      default: begin
        for (int i = 0; i < 5; i++) blkw[i] = idig[159-32*i -: 32];
        blkw[5]  = PAD_WORD;
        blkw[15] = OTAIL_BITS;
      end
    endcase
  end

  // round function
  logic [31:0] f, k, t, wn;
  always_comb begin
    if (cnt < 7'd20) begin
      f = (b & c) | (~b & d); k = K0;
    end else if (cnt < 7'd40) begin
      f = b ^ c ^ d; k = K1;
    end else if (cnt < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = K2;
    end else begin
      f = b ^ c ^ d; k = K3;
    end
    t  = {a[26:0], a[31:27]} + f + e + k + w[0];
    wn = w[13] ^ w[8] ^ w[2] ^ w[0];
    wn = {wn[30:0], wn[31]};
  end

  logic [31:0] s [5];
  assign s[0] = h[0] + a;
  assign s[1] = h[1] + b;
  assign s[2] = h[2] + c;
  assign s[3] = h[3] + d;
  assign s[4] = h[4] + e;

  // truncation
  logic [159:0] dv;
  logic [3:0]   off;
  assign dv  = {h[0], h[1], h[2], h[3], h[4]};
  assign off = dv[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load_in || cmd.blk_load) begin
      cnt <= '0;
    end else if (cmd.div_step || cmd.round) begin
      cnt <= cnt + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      quo <= timestamp;
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!cnt[0]) begin
        qd <= dprod[DS +: 8];
      end else begin
        quo <= {quo[55:0], qd};
        rem <= RW'(dr - RB'(qd) * TS);
      end
    end
    if (cmd.blk_load) begin
      for (int i = 0; i < 16; i++) w[i] <= blkw[i];
      if (!cmd.blk[0]) begin
        h[0] <= IV0; h[1] <= IV1; h[2] <= IV2; h[3] <= IV3; h[4] <= IV4;
        a <= IV0; b <= IV1; c <= IV2; d <= IV3; e <= IV4;
      end else begin
        a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= t;
    end else if (cmd.fold) begin
      for (int i = 0; i < 5; i++) h[i] <= s[i];
      if (cmd.blk == BLK_ITAIL) idig <= {s[0], s[1], s[2], s[3], s[4]};
    end
    if (cmd.trunc) begin
      code <= {dv[159-8*(32'(off)+2) -: 8], dv[159-8*(32'(off)+3) -: 8]};
    end
  end

  assign stat.div_last   = (cnt == DIV_LAST);
  assign stat.round_last = (cnt == ROUND_LAST);
endmodule

// ===== tb/totp_hmac_sha1_generator_core_test.sv =====
// Self-checking testbench for the TOTP HMAC-SHA1 generator core.
// Predicts each code with its own HMAC-SHA1 and truncation; depends on totp_pkg and the core.
`timescale 1ns / 1ps
module totp_hmac_sha1_generator_core_test;
  import totp_pkg::*;

  localparam int STEP_SECONDS = 300;
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  totp_hmac_sha1_generator_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  logic [63:0] key_a, key_b, key_c, key_d;
  logic [5:0]  key_len;
  logic [63:0] pending_stamps[$];
  logic [15:0] expected_codes[$];
  int          send_idle = 0;
  int          recv_idle = 0;
  int          errors = 0;
  int          codes_checked = 0;
  int          key_settings = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  function automatic logic [159:0] sha1_compress(input logic [159:0] chain,
                                                 input logic [511:0] blk);
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    int i;
    for (i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (i = 16; i < 80; i++) begin
      x = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
      w[i] = {x[30:0], x[31]};
    end
    {a, b, c, d, e} = chain;
    for (i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
    end
    return {chain[159:128] + a, chain[127:96] + b, chain[95:64] + c,
            chain[63:32] + d, chain[31:0] + e};
  endfunction

  function automatic logic [15:0] totp_code(input logic [63:0] stamp);
    logic [255:0] key_bytes;
    logic [511:0] key_block, blk;
    logic [159:0] iv, inner, outer;
    logic [63:0]  counter;
    int           lim, i, off;
    iv = {IV0, IV1, IV2, IV3, IV4};
    key_bytes = {key_a, key_b, key_c, key_d};
    lim = (key_len > KEY_STORE_BYTES) ? KEY_STORE_BYTES : key_len;
    for (i = lim; i < KEY_STORE_BYTES; i++) key_bytes[255 - 8 * i -: 8] = 8'h00;
    key_block = {key_bytes, 256'b0};
    counter = stamp / STEP_SECONDS;
    blk = '0;
    blk[511:448] = counter;
    blk[447:440] = 8'h80;
    blk[31:0] = ITAIL_BITS;
    inner = sha1_compress(sha1_compress(iv, key_block ^ {64{IPAD}}), blk);
    blk = '0;
    blk[511:352] = inner;
    blk[351:344] = 8'h80;
    blk[31:0] = OTAIL_BITS;
    outer = sha1_compress(sha1_compress(iv, key_block ^ {64{OPAD}}), blk);
    off = outer[3:0];
    return outer[159 - 8 * (off + 2) -: 16];
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_codes.push_back(totp_code(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (pending_stamps.size() > 0 && $urandom_range(99) >= send_idle) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_stamps.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_codes.size() == 0) begin
          $display("%0t: code %h with no request outstanding", $time, m_tdata);
          errors++;
        end else begin
          if (m_tdata !== expected_codes[0]) begin
            $display("%0t: code mismatch expected %h actual %h", $time,
                     expected_codes[0], m_tdata);
            errors++;
          end
          void'(expected_codes.pop_front());
          codes_checked++;
        end
      end
      if (!hold_done && codes_checked == 30) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL totp_hmac_sha1_generator_core");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KEY_A:   key_a = value;
      REG_KEY_B:   key_b = value;
      REG_KEY_C:   key_c = value;
      REG_KEY_D:   key_d = value;
      REG_KEY_LEN: key_len = value[5:0];
      default: ;
    endcase
  endtask

  task automatic load_key(input logic [63:0] a, input logic [63:0] b, input logic [63:0] c,
                          input logic [63:0] d, input logic [63:0] len);
    write_reg(REG_KEY_A, a);
    write_reg(REG_KEY_B, b);
    write_reg(REG_KEY_C, c);
    write_reg(REG_KEY_D, d);
    write_reg(REG_KEY_LEN, len);
    cfg_valid <= 1'b0;
    key_settings++;
  endtask

  task automatic drain();
    while (pending_stamps.size() > 0 || s_tvalid || expected_codes.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [63:0] random_stamp();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return {$urandom, $urandom};
    if (pick < 85) return 64'($urandom_range(100000));
    return 64'($urandom) * STEP_SECONDS + ($urandom_range(1) ? STEP_SECONDS - 1 : 0);
  endfunction

  function automatic logic [63:0] random_length();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return {$urandom, 26'h0, 6'd0} | 64'd0;
    if (pick == 1) return 64'd32;
    if (pick == 2) return {$urandom, 26'h0, 6'($urandom_range(63, 33))};
    if (pick == 3) return 64'd1;
    return {$urandom, 26'h0, 6'($urandom_range(31, 1))};
  endfunction

  initial begin
    int ph, n, idx;
    key_a = '0; key_b = '0; key_c = '0; key_d = '0; key_len = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ignored indexes must leave the empty reset key in place
    for (idx = REG_KEY_LEN + 1; idx < 8; idx++) write_reg(3'(idx), '1);
    cfg_valid <= 1'b0;
    pending_stamps = '{64'd0, 64'd299, 64'd300, 64'd599, '1, 64'h8000_0000_0000_0000};
    drain();

    load_key(64'h3132333435363738, 64'h3930313233343536, 64'h3738393000000000,
             64'h0, 64'd20);
    pending_stamps = '{64'd59, 64'd1111111109, 64'd1234567890, 64'd2000000000,
                       64'h5555_5555_5555_5555};
    drain();

    load_key('1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFF);
    pending_stamps = '{64'd0, '1, 64'hAAAA_AAAA_AAAA_AAAA, 64'd300};
    drain();

    load_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 64'hA5A5A5A55A5A5A5A,
             64'h0F1E2D3C4B5A6978, 64'd32);
    pending_stamps = '{64'd0, 64'd299, '1, 64'd86400};
    drain();

    for (ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_idle = 7; recv_idle = 50;
      end else if (ph < 6) begin
        send_idle = 50; recv_idle = 7;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, random_length());
      for (n = 0; n < 165; n++) pending_stamps.push_back(random_stamp());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d codes across %0d key settings, including empty,", codes_checked,
             key_settings);
    $display("saturated and full-length keys, with idle gaps and a long output stall.");
    if (errors == 0 && expected_codes.size() == 0) begin
      $display("PASS totp_hmac_sha1_generator_core");
    end else begin
      $display("FAIL totp_hmac_sha1_generator_core");
    end
    $finish;
  end
endmodule
